[hw/rtl/hkd_pkg.sv]
package hkd_pkg;

    localparam int KEY_SLOTS      = 6;
    localparam int PEND_W         = 2 * KEY_SLOTS + 1;
    localparam int ERR_BIT        = 2 * KEY_SLOTS;

    localparam logic [7:0] FIRST_KEY_CODE = 8'd4;
    localparam logic [7:0] MOD_CTRL_MASK  = 8'h11;
    localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;
    localparam logic [7:0] MOD_ALT_MASK   = 8'hCC;

    typedef logic [7:0]                      key_t;
    typedef logic [KEY_SLOTS-1:0][7:0]       key_array_t;
    typedef logic [2*KEY_SLOTS-1:0][7:0]     code_array_t;
    typedef logic [PEND_W-1:0]               pend_t;

    typedef enum logic [1:0] {
        EV_RELEASE = 2'd0,
        EV_PRESS   = 2'd1,
        EV_ERROR   = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic alt;
    } mods_t;

endpackage

[hw/rtl/hkd_diff.sv]
// Compares a report against the stored one and builds the pending event mask:
// bits [KEY_SLOTS-1:0] releases, [2*KEY_SLOTS-1:KEY_SLOTS] presses, top bit error.
module hkd_diff
    import hkd_pkg::*;
(
    input  key_array_t now_keys,
    input  key_array_t prev_keys,
    output logic       err,
    output pend_t      pend
);

    logic [KEY_SLOTS-1:0] rel_mask;
    logic [KEY_SLOTS-1:0] prs_mask;

    assign err = (now_keys[0] != 8'd0) && (now_keys[0] < FIRST_KEY_CODE);

    always_comb
    begin
        rel_mask = '0;
        prs_mask = '0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            logic in_now;
            logic in_prev;
            in_now  = 1'b0;
            in_prev = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++)
            begin
                if (now_keys[j] == prev_keys[i])
                begin
                    in_now = 1'b1;
                end
                if (prev_keys[j] == now_keys[i])
                begin
                    in_prev = 1'b1;
                end
            end
            rel_mask[i] = (prev_keys[i] >= FIRST_KEY_CODE) && !in_now;
            prs_mask[i] = (now_keys[i] >= FIRST_KEY_CODE) && !in_prev;
        end
    end

    // an error report carries only the error bit
    assign pend = err ? {1'b1, {(2*KEY_SLOTS){1'b0}}} : {1'b0, prs_mask, rel_mask};

endmodule

[hw/rtl/hkd_emit.sv]
// Drains the pending event mask lowest bit first into the output register,
// one word per cycle while that register is empty or its word is taken.
module hkd_emit
    import hkd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  pend_t        load_pend,
    input  code_array_t  load_codes,
    input  mods_t        load_mods,
    output logic         free,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [1:0]   event_kind,
    output logic [7:0]   key_code,
    output logic         shift_flag,
    output logic         ctrl_flag,
    output logic         alt_flag,
    output logic         last_event
);

    pend_t        pend_reg;
    pend_t        pend_next;
    code_array_t  codes_reg;
    mods_t        mods_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    event_kind_t  kind_reg;
    key_t         code_reg;
    mods_t        omods_reg;
    logic         last_reg;

    pend_t        pick;
    pend_t        rest;
    logic         pend_any;
    logic         emit_go;
    key_t         sel_code;
    event_kind_t  sel_kind;

    assign pend_any = |pend_reg;
    assign pick     = pend_reg & (~pend_reg + pend_t'(1));
    assign rest     = pend_reg & ~pick;
    assign emit_go  = pend_any && (!out_valid_reg || out_ready);
    assign free     = !pend_any || (emit_go && (rest == '0));

    always_comb
    begin
        sel_code = '0;
        for (int i = 0; i < 2 * KEY_SLOTS; i++)
        begin
            if (pick[i])
            begin
                sel_code = sel_code | codes_reg[i];
            end
        end
        if (pick[ERR_BIT])
        begin
            sel_kind = EV_ERROR;
        end
        else if (|pick[2*KEY_SLOTS-1:KEY_SLOTS])
        begin
            sel_kind = EV_PRESS;
        end
        else
        begin
            sel_kind = EV_RELEASE;
        end
    end

    always_comb
    begin
        pend_next = emit_go ? rest : pend_reg;
        if (load)
        begin
            pend_next = load_pend;
        end
        if (emit_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            codes_reg <= load_codes;
            mods_reg  <= load_mods;
        end
        if (emit_go)
        begin
            kind_reg  <= sel_kind;
            code_reg  <= sel_code;
            omods_reg <= mods_reg;
            last_reg  <= (rest == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = kind_reg;
    assign key_code   = code_reg;
    assign shift_flag = omods_reg.shift;
    assign ctrl_flag  = omods_reg.ctrl;
    assign alt_flag   = omods_reg.alt;
    assign last_event = last_reg;

    // error word never shares a run with key events
    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg[ERR_BIT] |-> (pend_reg[2*KEY_SLOTS-1:0] == '0))
        else $error("error bit pending together with key events");

    // an emitted word retires exactly its own pending bit
    a_retire: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go && !load |=> pend_reg == ($past(pend_reg) & ~$past(pick)))
        else $error("pending mask not retired correctly");

    // a new run is taken only once the current one is finished
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!pend_any || (emit_go && (rest == '0))))
        else $error("run loaded over pending events");

    // error word always carries code zero and closes its run
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == EV_ERROR) |-> (code_reg == '0) && last_reg)
        else $error("malformed error word");

endmodule

[hw/rtl/hid_report_key_event_diff_unit.sv]
// HID boot keyboard report differ. Each input word is one boot report (modifier
// byte plus six key slots). The report is registered, compared against the key
// slots of the previous accepted non-error report, and the resulting events come
// out one word per cycle while out_ready allows: first releases in stored-slot
// order, then presses in new-slot order, the final word of a report flagged by
// last_event. A report with 1..3 in key_slot_0 gives a single error word
// (event_kind 2, key_code 0) and leaves the stored slots alone; a report
// that changes nothing gives no words but still replaces the stored slots.
// Shift/ctrl/alt flags follow the report's own modifier byte (gui counts as
// alt). A report gives N (0..12) events and holds the event emitter until its
// last word moves into the single output register; the next report is compared
// and loaded in the cycle that last word leaves the emitter, so reports causing
// at most one event stream at one per cycle while out_ready allows. A report
// passes the input register and the pending mask before its first word reaches
// the output register. No clearing pass after reset.
module hid_report_key_event_diff_unit
    import hkd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  modifier_bits,
    input  logic [7:0]  key_slot_0,
    input  logic [7:0]  key_slot_1,
    input  logic [7:0]  key_slot_2,
    input  logic [7:0]  key_slot_3,
    input  logic [7:0]  key_slot_4,
    input  logic [7:0]  key_slot_5,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_kind,
    output logic [7:0]  key_code,
    output logic        shift_flag,
    output logic        ctrl_flag,
    output logic        alt_flag,
    output logic        last_event
);

    // input register
    logic        in_full_reg;
    logic        in_full_next;
    key_array_t  slots_reg;
    mods_t       mods_reg;

    // key slots of the last accepted non-error report
    key_array_t  prev_keys_reg;

    logic        load;
    logic        emit_free;
    logic        diff_err;
    pend_t       diff_pend;
    mods_t       in_mods;
    logic        in_take;

    assign in_mods.shift = |(modifier_bits & MOD_SHIFT_MASK);
    assign in_mods.ctrl  = |(modifier_bits & MOD_CTRL_MASK);
    assign in_mods.alt   = |(modifier_bits & MOD_ALT_MASK);

    // report moves into the emitter once the previous run is done or is draining its last word
    assign load     = in_full_reg && emit_free;
    assign in_ready = !in_full_reg || load;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        if (in_take)
        begin
            in_full_next = 1'b1;
        end
        else if (load)
        begin
            in_full_next = 1'b0;
        end
        else
        begin
            in_full_next = in_full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            prev_keys_reg <= '0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            // an error report leaves the stored slots untouched
            if (load && !diff_err)
            begin
                prev_keys_reg <= slots_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            slots_reg[0] <= key_slot_0;
            slots_reg[1] <= key_slot_1;
            slots_reg[2] <= key_slot_2;
            slots_reg[3] <= key_slot_3;
            slots_reg[4] <= key_slot_4;
            slots_reg[5] <= key_slot_5;
            mods_reg     <= in_mods;
        end
    end

    hkd_diff u_diff (
        .now_keys  (slots_reg),
        .prev_keys (prev_keys_reg),
        .err       (diff_err),
        .pend      (diff_pend)
    );

    // low half of the code array: stored slots (releases), high half: new slots (presses)
    hkd_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_pend  (diff_pend),
        .load_codes ({slots_reg, prev_keys_reg}),
        .load_mods  (mods_reg),
        .free       (emit_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .key_code   (key_code),
        .shift_flag (shift_flag),
        .ctrl_flag  (ctrl_flag),
        .alt_flag   (alt_flag),
        .last_event (last_event)
    );

endmodule

[verif/hid_report_key_event_diff_unit_tb.sv]
`timescale 1ns / 1ps

module hid_report_key_event_diff_unit_tb;
    import hkd_pkg::*;

    // One event word as the block should emit it.
    typedef struct packed {
        event_kind_t kind;
        key_t        code;
        logic        shift;
        logic        ctrl;
        logic        alt;
        logic        last_ev;
    } event_word_t;

    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int DRAIN_PAD   = 6;
    localparam int MAX_GAP     = 20;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] modifier_bits = 8'h00;
    logic [7:0] key_slot_0 = 8'h00;
    logic [7:0] key_slot_1 = 8'h00;
    logic [7:0] key_slot_2 = 8'h00;
    logic [7:0] key_slot_3 = 8'h00;
    logic [7:0] key_slot_4 = 8'h00;
    logic [7:0] key_slot_5 = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] event_kind;
    logic [7:0] key_code;
    logic       shift_flag;
    logic       ctrl_flag;
    logic       alt_flag;
    logic       last_event;

    // Predictor state: key slots of the last accepted non-error report.
    key_array_t  held_keys = '0;
    event_word_t expected_events[$];

    // Stimulus-side copy of the last report sent, used to build
    // reports that overlap the previous one.
    key_array_t  last_sent = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    int mismatches = 0;
    int reports_accepted = 0;
    int words_checked = 0;
    int error_words = 0;
    int stall_cycles = 0;

    hid_report_key_event_diff_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .modifier_bits (modifier_bits),
        .key_slot_0    (key_slot_0),
        .key_slot_1    (key_slot_1),
        .key_slot_2    (key_slot_2),
        .key_slot_3    (key_slot_3),
        .key_slot_4    (key_slot_4),
        .key_slot_5    (key_slot_5),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_kind    (event_kind),
        .key_code      (key_code),
        .shift_flag    (shift_flag),
        .ctrl_flag     (ctrl_flag),
        .alt_flag      (alt_flag),
        .last_event    (last_event)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic bit slots_hold(key_array_t slots, key_t code);
        for (int i = 0; i < KEY_SLOTS; i++)
            if (slots[i] == code)
                return 1'b1;
        return 1'b0;
    endfunction

    // Queues the event words caused by one report and updates the held
    // slots. Releases come first in stored-slot order, then presses in
    // new-slot order; every slot is judged on its own, so duplicates
    // each produce a word.
    function automatic void diff_report(logic [7:0] mods, key_array_t now);
        event_word_t batch[$];
        event_word_t w;
        key_t        c;
        w.shift   = |(mods & MOD_SHIFT_MASK);
        w.ctrl    = |(mods & MOD_CTRL_MASK);
        w.alt     = |(mods & MOD_ALT_MASK);
        w.last_ev = 1'b0;

        // Error report: one word, held slots untouched.
        if (now[0] != 8'd0 && now[0] < FIRST_KEY_CODE)
        begin
            w.kind    = EV_ERROR;
            w.code    = 8'd0;
            w.last_ev = 1'b1;
            expected_events.push_back(w);
            return;
        end

        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            c = held_keys[i];
            if (c >= FIRST_KEY_CODE && !slots_hold(now, c))
            begin
                w.kind = EV_RELEASE;
                w.code = c;
                batch.push_back(w);
            end
        end
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            c = now[i];
            if (c >= FIRST_KEY_CODE && !slots_hold(held_keys, c))
            begin
                w.kind = EV_PRESS;
                w.code = c;
                batch.push_back(w);
            end
        end

        // Codes 1..3 outside slot 0 are stored even though they give no event.
        held_keys = now;

        for (int i = 0; i < batch.size(); i++)
        begin
            w = batch[i];
            w.last_ev = (i == batch.size() - 1);
            expected_events.push_back(w);
        end
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: predict on input accept, compare on output accept.
    // Sampled at the rising edge, before this edge's drives take effect.
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        event_word_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                reports_accepted++;
                diff_report(modifier_bits, {key_slot_5, key_slot_4, key_slot_3,
                                            key_slot_2, key_slot_1, key_slot_0});
            end
            if (in_valid && !in_ready)
                stall_cycles++;
            if (out_valid && out_ready)
            begin
                words_checked++;
                if (expected_events.size() == 0)
                begin
                    report_mismatch("unexpected word, key_code", key_code, -1);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (want.kind == EV_ERROR)
                        error_words++;
                    if (event_kind != want.kind)
                        report_mismatch("event_kind", event_kind, want.kind);
                    if (key_code != want.code)
                        report_mismatch("key_code", key_code, want.code);
                    if (shift_flag != want.shift)
                        report_mismatch("shift_flag", shift_flag, want.shift);
                    if (ctrl_flag != want.ctrl)
                        report_mismatch("ctrl_flag", ctrl_flag, want.ctrl);
                    if (alt_flag != want.alt)
                        report_mismatch("alt_flag", alt_flag, want.alt);
                    if (last_event != want.last_ev)
                        report_mismatch("last_event", last_event, want.last_ev);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request. The
    // hold-off is counted here so the sender can keep pushing reports
    // until the block backs up and drops in_ready.
    // ------------------------------------------------------------------

    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_served < hold_requests)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offers one report word and returns at the edge where it is taken.
    // in_valid is left high so a back-to-back word needs only one drive
    // per edge; anything that pauses the sender lowers it first.
    task automatic send_report(input logic [7:0] mods,
                               input key_t k0, input key_t k1, input key_t k2,
                               input key_t k3, input key_t k4, input key_t k5);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        modifier_bits <= mods;
        key_slot_0    <= k0;
        key_slot_1    <= k1;
        key_slot_2    <= k2;
        key_slot_3    <= k3;
        key_slot_4    <= k4;
        key_slot_5    <= k5;
        last_sent      = {k5, k4, k3, k2, k1, k0};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Sender goes quiet until every expected word has come out. One edge
    // first, so the last accepted report is already predicted.
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic set_idling(int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // Mostly reports built from a small key pool with overlap against the
    // previous report, so presses, releases and held keys all mix; the rest
    // are error reports, full-range noise and repeats.
    task automatic send_random_report();
        key_array_t k;
        logic [7:0] mods;
        int         r;
        mods = 8'($urandom());
        r    = $urandom_range(99);
        if (r < 8)
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
                k[i] = 8'($urandom());
            k[0] = 8'($urandom_range(1, 3));
        end
        else if (r < 18)
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
                k[i] = 8'($urandom());
        end
        else if (r < 28)
        begin
            k = last_sent;
        end
        else
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                if ($urandom_range(99) < 45)
                    k[i] = last_sent[i];
                else if ($urandom_range(99) < 40)
                    k[i] = 8'd0;
                else if (i != 0 && $urandom_range(99) < 6)
                    k[i] = 8'($urandom_range(1, 3));
                else
                    k[i] = 8'($urandom_range(4, 13));
            end
            // A stale error code copied into slot 0 would turn this into
            // an error report; keep those to the error branch.
            if (k[0] != 8'd0 && k[0] < FIRST_KEY_CODE)
                k[0] = 8'd0;
        end
        send_report(mods, k[0], k[1], k[2], k[3], k[4], k[5]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_single_keys();
        send_report(8'h00, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);     // KEY_A down
        send_report(8'hFF, 8'd4, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);   // top code, all mods
        send_report(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);     // both up
        send_report(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);     // no change
        wait_drain();
    endtask

    // Six keys down, then six others: the worst case of twelve words.
    task automatic test_full_rollover();
        send_report(8'h00, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9);
        send_report(8'h5A, 8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd255);
        send_report(8'hA5, 8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd255);
        send_report(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        wait_drain();
    endtask

    // Error reports must not touch the held slots, so the report after
    // them matches the one before and gives nothing.
    task automatic test_error_reports();
        send_report(8'h01, 8'd4, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0);
        send_report(8'h22, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_report(8'h44, 8'd2, 8'd200, 8'd201, 8'd202, 8'd203, 8'd204);
        send_report(8'h88, 8'd3, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        send_report(8'h00, 8'd4, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0);
        wait_drain();
    endtask

    // Duplicate codes each give a word; reserved codes 1..3 in later
    // slots are stored silently.
    task automatic test_duplicates_and_reserved();
        send_report(8'h00, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5);
        send_report(8'h00, 8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd0);
        send_report(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_report(8'h00, 8'd6, 8'd1, 8'd2, 8'd3, 8'd6, 8'd0);
        wait_drain();
    endtask

    // One modifier bit at a time, with a key swap so every report emits.
    task automatic test_modifier_flags();
        for (int b = 0; b < 8; b++)
            send_report(8'(1 << b), (b % 2 == 0) ? 8'd4 : 8'd7,
                        8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        wait_drain();
    endtask

    // Receiver holds off while the sender streams random reports,
    // so the output backs up and in_ready must drop.
    task automatic test_backpressure_fill();
        set_idling(0, 0);
        hold_requests++;
        repeat (40) send_random_report();
        wait_drain();
    endtask

    task automatic test_random_traffic(int tx_pct, int rx_pct, int count);
        set_idling(tx_pct, rx_pct);
        repeat (count) send_random_report();
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(16, 48);
        test_single_keys();
        test_full_rollover();
        test_error_reports();
        test_duplicates_and_reserved();
        test_modifier_flags();

        test_random_traffic(16, 48, 120);
        test_random_traffic(48, 16, 120);
        test_random_traffic(0, 0, 120);
        test_backpressure_fill();

        repeat (DRAIN_PAD) @(posedge clk);
        if (expected_events.size() != 0)
            report_mismatch("words never emitted", 0, expected_events.size());

        $display("Run covered %0d reports and %0d event words (%0d error words),",
                 reports_accepted, words_checked, error_words);
        $display("with input stalled for %0d cycles under output back-pressure.",
                 stall_cycles);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("Timed out with %0d words still expected", expected_events.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[hid_report_key_event_diff_unit.f]
hw/rtl/hkd_pkg.sv
hw/rtl/hkd_diff.sv
hw/rtl/hkd_emit.sv
hw/rtl/hid_report_key_event_diff_unit.sv
verif/hid_report_key_event_diff_unit_tb.sv
